[rtl/psd_pkg.sv]
package psd_pkg;

   localparam int MAX_COUNT  = 1024;
   localparam int SCORE_W    = 16;
   localparam int COUNT_W    = 11;
   localparam int SUM_W      = 26;
   localparam int SQ_W       = 42;
   localparam int STD_W      = 24;

   // n*S2 - S1^2 in two's complement, one spare sign bit
   localparam int DIFF_W     = 54;
   // radicand 65536*d, padded to an even width
   localparam int RAD_W      = 70;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 3;

   localparam int MUL_STEPS  = SUM_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = ROOT_W;
   localparam int STEP_W     = 6;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [STD_W-1:0]   std_dev_q8;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } rsp_type;

endpackage

[rtl/population_std_deviation_core.sv]
// Population standard deviation of a set of unsigned 16-bit scores.
//
// Input: drive req_item with start high; a beat is taken at any rising edge
// where start is high and busy is low. Scores accumulate one per cycle, so
// while a set is open a new beat can be taken every cycle. A beat with
// last set closes the set; scores beyond MAX_COUNT are dropped and flagged.
//
// Closing a set runs three bit-serial passes, one step per cycle:
//   multiply  n*S2 - S1^2          (one bit of n and of S1 a step)
//   sqrt      of 65536*d           (two radicand bits a step)
//   divide    root / n             (restoring, one quotient bit)
// busy is high throughout; when the divide pass ends, rsp_valid strobes
// for one cycle, with rsp_item holding the Q.8 deviation, the count and
// the overflow flag. The result is presented once and the receiver
// cannot stall it; busy drops with the strobe, so the next set may start
// in that same cycle.
//
// Reset (synchronous, active high) clears the sums and returns to idle.
module population_std_deviation_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  psd_pkg::req_type  req_item,
   output logic              rsp_valid,
   output psd_pkg::rsp_type  rsp_item
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_SQRT = 2'd2;
   localparam logic [1:0] ST_DIV  = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [psd_pkg::STEP_W-1:0]    step_ff, step_in;

   logic [psd_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [psd_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [psd_pkg::SQ_W-1:0]      sq_ff, sq_in;
   logic                          too_many_ff, too_many_in;

   logic [psd_pkg::DIFF_W-1:0]    acc_ff, acc_in;
   logic [psd_pkg::DIFF_W-1:0]    mcq_ff, mcq_in;
   logic [psd_pkg::DIFF_W-1:0]    mcs_ff, mcs_in;
   logic [psd_pkg::COUNT_W-1:0]   mpn_ff, mpn_in;
   logic [psd_pkg::SUM_W-1:0]     mps_ff, mps_in;

   logic [psd_pkg::RAD_W-1:0]     rad_ff, rad_in;
   logic [psd_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [psd_pkg::REM_W-1:0]     rem_ff, rem_in;

   logic [psd_pkg::ROOT_W-1:0]    dvd_ff, dvd_in;
   logic [psd_pkg::COUNT_W-1:0]   drem_ff, drem_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   psd_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          take;
   logic [2*psd_pkg::SCORE_W-1:0] score_sq;
   logic [psd_pkg::DIFF_W-1:0]    mul_sum;
   logic [psd_pkg::DIFF_W-2:0]    diff_pos;
   logic [psd_pkg::REM_W+1:0]     rem_shift;
   logic [psd_pkg::REM_W+1:0]     trial;
   logic [psd_pkg::COUNT_W:0]     div_part;
   logic                          qbit;
   logic                          step_last;

   assign busy      = (state_ff != ST_IDLE);
   assign take      = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign score_sq  = req_item.score * req_item.score;
   assign step_last = (step_ff == '0);

   assign mul_sum = acc_ff
                  + (mpn_ff[0] ? mcq_ff : '0)
                  - (mps_ff[0] ? mcs_ff : '0);
   assign diff_pos = mul_sum[psd_pkg::DIFF_W-1] ? '0 : mul_sum[psd_pkg::DIFF_W-2:0];

   assign rem_shift = {rem_ff, rad_ff[psd_pkg::RAD_W-1 -: 2]};
   assign trial     = {3'b000, root_ff, 2'b01};

   assign div_part  = {drem_ff, dvd_ff[psd_pkg::ROOT_W-1]};
   assign qbit      = (div_part >= {1'b0, count_ff});

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      too_many_in  = too_many_ff;
      acc_in       = acc_ff;
      mcq_in       = mcq_ff;
      mcs_in       = mcs_ff;
      mpn_in       = mpn_ff;
      mps_in       = mps_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      drem_in      = drem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (count_ff < psd_pkg::COUNT_W'(psd_pkg::MAX_COUNT)) begin
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + psd_pkg::SUM_W'(req_item.score);
                  sq_in    = sq_ff + psd_pkg::SQ_W'(score_sq);
               end else begin
                  too_many_in = 1'b1;
               end
               if (req_item.last) begin
                  state_in = ST_MUL;
                  step_in  = psd_pkg::STEP_W'(psd_pkg::MUL_STEPS - 1);
                  acc_in   = '0;
                  mcq_in   = psd_pkg::DIFF_W'(sq_in);
                  mcs_in   = psd_pkg::DIFF_W'(sum_in);
                  mpn_in   = count_in;
                  mps_in   = sum_in;
               end
            end
         end
         ST_MUL: begin
            acc_in  = mul_sum;
            mcq_in  = {mcq_ff[psd_pkg::DIFF_W-2:0], 1'b0};
            mcs_in  = {mcs_ff[psd_pkg::DIFF_W-2:0], 1'b0};
            mpn_in  = mpn_ff >> 1;
            mps_in  = mps_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_last) begin
               state_in = ST_SQRT;
               step_in  = psd_pkg::STEP_W'(psd_pkg::SQRT_STEPS - 1);
               rad_in   = {1'b0, diff_pos, 16'h0000};
               root_in  = '0;
               rem_in   = '0;
            end
         end
         ST_SQRT: begin
            rad_in  = {rad_ff[psd_pkg::RAD_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (rem_shift >= trial) begin
               rem_in  = psd_pkg::REM_W'(rem_shift - trial);
               root_in = {root_ff[psd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = psd_pkg::REM_W'(rem_shift);
               root_in = {root_ff[psd_pkg::ROOT_W-2:0], 1'b0};
            end
            if (step_last) begin
               state_in = ST_DIV;
               step_in  = psd_pkg::STEP_W'(psd_pkg::DIV_STEPS - 1);
               dvd_in   = root_in;
               drem_in  = '0;
            end
         end
         ST_DIV: begin
            step_in = step_ff - 1'b1;
            dvd_in  = {dvd_ff[psd_pkg::ROOT_W-2:0], qbit};
            drem_in = qbit ? psd_pkg::COUNT_W'(div_part - {1'b0, count_ff})
                           : psd_pkg::COUNT_W'(div_part);
            if (step_last) begin
               state_in          = ST_IDLE;
               rsp_valid_in      = 1'b1;
               rsp_in.std_dev_q8 = dvd_in[psd_pkg::STD_W-1:0];
               rsp_in.count      = count_ff;
               rsp_in.overflow   = too_many_ff;
               count_in          = '0;
               sum_in            = '0;
               sq_in             = '0;
               too_many_in       = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         too_many_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         too_many_ff  <= too_many_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mcq_ff  <= mcq_in;
      mcs_ff  <= mcs_in;
      mpn_ff  <= mpn_in;
      mps_ff  <= mps_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      drem_ff <= drem_in;
      rsp_ff  <= rsp_in;
   end

endmodule
